// File: sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define B85_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define B85_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define B85_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/b85_pkg.sv
// shared types, constants and digit/character mapping for the base-85 word codec
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package b85_pkg;

  localparam int WORD_W     = 32;
  localparam int ACC_W      = 33;  // 85^5 - 1 fits in 33 bits
  localparam int CHAR_IN_W  = 8;
  localparam int CHAR_OUT_W = 7;
  localparam int DIGITS     = 5;
  localparam int RADIX      = 85;
  localparam int NUM_PUNCT  = 23;

  // reciprocal of 85: floor(w * magic / 2^38) == w / 85 for every 32-bit w
  localparam logic [WORD_W-1:0] DIV85_MAGIC = 32'hC0C0C0C1;
  localparam int                DIV85_SHIFT = 38;

  localparam logic [6:0] DIGIT_BAD = 7'(RADIX);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // punctuation tail of the alphabet, digits 62 to 84
  localparam logic [CHAR_IN_W-1:0] PUNCT_TBL [NUM_PUNCT] = '{
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
    8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
  };

  // one pipeline beat as it walks down the row of cells
  typedef struct packed {
    op_t                                op;
    logic [WORD_W-1:0]                  w;    // value still to split
    logic [WORD_W-1:0]                  q;    // w / 85, formed one stage ahead
    logic [ACC_W-1:0]                   acc;  // decode accumulator
    logic                               err;  // bad character seen
    logic [DIGITS-1:0][CHAR_IN_W-1:0]   cin;  // characters left to decode
    logic [DIGITS-1:0][CHAR_OUT_W-1:0]  cout; // encoded characters so far
  } stage_t;

  // word / 85 by reciprocal multiply
  function automatic logic [WORD_W-1:0] div85(input logic [WORD_W-1:0] w);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(w) * (2*WORD_W)'(DIV85_MAGIC);
    return WORD_W'(prod >> DIV85_SHIFT);
  endfunction

  // digit 0..84 to its ascii code
  function automatic logic [CHAR_OUT_W-1:0] char_of(input logic [6:0] d);
    logic [CHAR_OUT_W-1:0] c;
    logic [4:0]            idx;
    idx = 5'(d - 7'd62);
    c   = '0;
    if (d < 7'd10) begin
      c = 7'(7'h30 + d);
    end else if (d < 7'd36) begin
      c = 7'(7'h41 + d - 7'd10);
    end else if (d < 7'd62) begin
      c = 7'(7'h61 + d - 7'd36);
    end else if (idx < 5'(NUM_PUNCT)) begin
      c = CHAR_OUT_W'(PUNCT_TBL[idx]);
    end
    return c;
  endfunction

  // ascii code to digit, DIGIT_BAD when outside the alphabet
  function automatic logic [6:0] digit_of(input logic [CHAR_IN_W-1:0] c);
    logic [6:0] d;
    d = DIGIT_BAD;
    if (c inside {[8'h30:8'h39]}) begin
      d = 7'(c - 8'h30);
    end else if (c inside {[8'h41:8'h5A]}) begin
      d = 7'(c - 8'h37);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = 7'(c - 8'h3D);
    end else begin
      for (int i = 0; i < NUM_PUNCT; i++) begin
        if (c == PUNCT_TBL[i]) begin
          d = 7'(62 + i);
        end
      end
    end
    return d;
  endfunction

endpackage

// File: sv/b85_if.sv
// valid/ready channel interfaces for the codec's input and result beats
// depends on b85_pkg for field widths
`timescale 1ns / 1ps

interface b85_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [b85_pkg::WORD_W-1:0]         word_in;
  logic [b85_pkg::CHAR_IN_W-1:0]      char_in_0;
  logic [b85_pkg::CHAR_IN_W-1:0]      char_in_1;
  logic [b85_pkg::CHAR_IN_W-1:0]      char_in_2;
  logic [b85_pkg::CHAR_IN_W-1:0]      char_in_3;
  logic [b85_pkg::CHAR_IN_W-1:0]      char_in_4;

  modport source (
    output valid, operation, word_in, char_in_0, char_in_1, char_in_2, char_in_3, char_in_4,
    input  ready
  );
  modport sink (
    input  valid, operation, word_in, char_in_0, char_in_1, char_in_2, char_in_3, char_in_4,
    output ready
  );
endinterface

interface b85_out_if;
  logic                               valid;
  logic                               ready;
  logic [b85_pkg::WORD_W-1:0]         word_out;
  logic [b85_pkg::CHAR_OUT_W-1:0]     char_out_0;
  logic [b85_pkg::CHAR_OUT_W-1:0]     char_out_1;
  logic [b85_pkg::CHAR_OUT_W-1:0]     char_out_2;
  logic [b85_pkg::CHAR_OUT_W-1:0]     char_out_3;
  logic [b85_pkg::CHAR_OUT_W-1:0]     char_out_4;
  logic                               valid_res;
  logic                               overflow;

  modport source (
    output valid, word_out, char_out_0, char_out_1, char_out_2, char_out_3, char_out_4,
           valid_res, overflow,
    input  ready
  );
  modport sink (
    input  valid, word_out, char_out_0, char_out_1, char_out_2, char_out_3, char_out_4,
           valid_res, overflow,
    output ready
  );
endinterface

// File: sv/base85_word_codec.sv
// top level of the base-85 word codec: entry register and a row of five digit cells
// depends on b85_pkg, b85_if and b85_cell
`timescale 1ns / 1ps

// Converts one 32-bit word to five RFC 1924 base-85 characters, or five characters
// back to a word, per beat; operation selects the direction. One beat is accepted every
// cycle unless all stages are full and stalled; beats pass one entry register, where a
// 32x32 reciprocal multiplier forms the first quotient by 85, then five identical
// cells, one per digit, the last of which is the output register. Each stage holds
// its beat only while the next stage is full and stalled, so in_bus.ready drops only
// when every stage is occupied and out_bus.ready is low. Decode flags a bad character
// with valid_res low and word_out zero, and flags a value above 2^32-1 with overflow
// while word_out keeps its low 32 bits. No memory, no clearing pass after reset.
module base85_word_codec (
  input  logic      clk,
  input  logic      rst_n,
  b85_in_if.sink    in_bus,
  b85_out_if.source out_bus
);
  import b85_pkg::*;

  logic   entry_valid_r;
  stage_t entry_r;
  stage_t entry_nxt;
  logic   entry_ready;

  stage_t             link_data [DIGITS+1];
  logic [DIGITS:0]    link_valid;
  logic [DIGITS:0]    link_ready;
  stage_t             last;

  // entry beat: capture the fields and the first quotient
  always_comb begin
    entry_nxt         = '0;
    entry_nxt.op      = op_t'(in_bus.operation);
    entry_nxt.w       = in_bus.word_in;
    entry_nxt.q       = div85(in_bus.word_in);
    entry_nxt.cin[0]  = in_bus.char_in_0;
    entry_nxt.cin[1]  = in_bus.char_in_1;
    entry_nxt.cin[2]  = in_bus.char_in_2;
    entry_nxt.cin[3]  = in_bus.char_in_3;
    entry_nxt.cin[4]  = in_bus.char_in_4;
  end

  assign entry_ready  = !entry_valid_r || link_ready[0];
  assign in_bus.ready = entry_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (entry_ready) begin
      entry_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ready && in_bus.valid) begin
      entry_r <= entry_nxt;
    end
  end

  assign link_valid[0] = entry_valid_r;
  assign link_data[0]  = entry_r;

  // row of digit cells
  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    b85_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  assign link_ready[DIGITS] = out_bus.ready;
  assign last               = link_data[DIGITS];

  // result beat from the last cell
  assign out_bus.valid      = link_valid[DIGITS];
  assign out_bus.word_out   = last.err ? '0 : last.acc[WORD_W-1:0];
  assign out_bus.valid_res  = !last.err;
  assign out_bus.overflow   = !last.err && last.acc[ACC_W-1];
  assign out_bus.char_out_0 = last.cout[0];
  assign out_bus.char_out_1 = last.cout[1];
  assign out_bus.char_out_2 = last.cout[2];
  assign out_bus.char_out_3 = last.cout[3];
  assign out_bus.char_out_4 = last.cout[4];

endmodule

// File: sv/b85_cell.sv
// one digit cell: splits off one base-85 digit or folds in one decoded character
// depends on b85_pkg for stage_t, div85, char_of and digit_of
`timescale 1ns / 1ps

module b85_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  b85_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output b85_pkg::stage_t dn_data
);
  import b85_pkg::*;

  logic              valid_r;
  stage_t            data_r;
  stage_t            data_nxt;
  logic [WORD_W-1:0] q_times85;
  logic [6:0]        rem;
  logic [6:0]        dig;
  logic [ACC_W-1:0]  acc_times85;

  // constant multiplies by 85 as shift-add
  assign q_times85   = (up_data.q << 6) + (up_data.q << 4) + (up_data.q << 2) + up_data.q;
  assign acc_times85 = (up_data.acc << 6) + (up_data.acc << 4) + (up_data.acc << 2)
                     + up_data.acc;
  assign rem         = 7'(up_data.w - q_times85);
  assign dig         = digit_of(up_data.cin[0]);

  // digit step
  always_comb begin
    data_nxt = up_data;
    for (int i = 1; i < DIGITS; i++) begin
      data_nxt.cout[i] = up_data.cout[i-1];
    end
    for (int i = 0; i < DIGITS - 1; i++) begin
      data_nxt.cin[i] = up_data.cin[i+1];
    end
    data_nxt.cin[DIGITS-1] = '0;
    if (up_data.op == OP_ENCODE) begin
      data_nxt.cout[0] = char_of(rem);
      data_nxt.w       = up_data.q;
      data_nxt.q       = div85(up_data.q);
    end else begin
      data_nxt.cout[0] = '0;
      data_nxt.acc     = acc_times85 + ACC_W'(dig);
      data_nxt.err     = up_data.err | (dig == DIGIT_BAD);
    end
  end

  // stage handshake: take a beat when empty or when the neighbor takes ours
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: sv/b85_checker.sv
// port-level checks for the base-85 word codec, bound to the top level
// depends on assert_macros.svh and base85_word_codec
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b85_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] word_out,
  input logic        valid_res,
  input logic        overflow
);

  // a stalled result beat stays put
  `B85_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_out), "result beat changed while stalled")

  // reset empties the pipeline
  `B85_ASSERT_RESET(a_reset_empty, !rst_n, !out_valid, "result beat right after reset")

  // input backs up only when the output side holds a beat
  `B85_ASSERT_IMPL(a_ready_backpressure, in_valid && !in_ready, out_valid && !out_ready, "input stalled with room in the pipeline")

  // a rejected decode carries no word and no overflow
  `B85_ASSERT_IMPL(a_bad_zero, out_valid && !valid_res, word_out == 32'd0 && !overflow, "bad decode with nonzero word or overflow")

endmodule

bind base85_word_codec b85_checker u_b85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .word_out  (out_bus.word_out),
  .valid_res (out_bus.valid_res),
  .overflow  (out_bus.overflow)
);

// File: tb/sv/tb_top.sv
// testbench for base85_word_codec: random and directed encode/decode beats with a scoreboard
// depends on b85_pkg, b85_if and the codec rtl
`timescale 1ns / 1ps

// one expected or observed result beat
typedef struct packed {
  logic [31:0]     word;
  logic [4:0][6:0] chars;
  logic            valid_res;
  logic            overflow;
} b85_result_t;

// predicts each conversion and checks result beats in order
class b85_scoreboard;
  logic [7:0]  glyph [85];
  b85_result_t pending [$];
  int          mismatches;
  int          results_seen;

  function new();
    logic [7:0] punct [23];
    punct = '{8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B,
              8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D,
              8'h7E};
    mismatches   = 0;
    results_seen = 0;
    for (int i = 0; i < 10; i++) glyph[i] = 8'(8'h30 + i);
    for (int i = 0; i < 26; i++) glyph[10 + i] = 8'(8'h41 + i);
    for (int i = 0; i < 26; i++) glyph[36 + i] = 8'(8'h61 + i);
    for (int i = 0; i < 23; i++) glyph[62 + i] = punct[i];
  endfunction

  // digit of a character, -1 when it is not in the alphabet
  function int digit_value(logic [7:0] c);
    if (c == 8'h00 || c >= 8'h80) return -1;
    for (int i = 0; i < 85; i++) begin
      if (glyph[i] == c) return i;
    end
    return -1;
  endfunction

  function b85_result_t convert(b85_pkg::op_t op, logic [31:0] w, logic [4:0][7:0] cs);
    b85_result_t res;
    logic [31:0] rest;
    logic [63:0] acc;
    int          d;
    res = '0;
    if (op == b85_pkg::OP_ENCODE) begin
      // least significant digit lands in the last character
      rest = w;
      for (int k = 4; k >= 0; k--) begin
        res.chars[k] = glyph[rest % 85][6:0];
        rest = rest / 85;
      end
      res.valid_res = 1'b1;
    end else begin
      acc = '0;
      for (int k = 0; k < 5; k++) begin
        d = digit_value(cs[k]);
        if (d < 0) return '0;
        acc = acc * 85 + d;
      end
      res.word      = acc[31:0];
      res.valid_res = 1'b1;
      res.overflow  = (acc > 64'hFFFF_FFFF);
    end
    return res;
  endfunction

  function void note_input(b85_pkg::op_t op, logic [31:0] w, logic [4:0][7:0] cs);
    pending.push_back(convert(op, w, cs));
  endfunction

  function void check_result(b85_result_t got);
    b85_result_t exp;
    results_seen++;
    if (pending.size() == 0) begin
      if (mismatches < 10)
        $display("result %0d: no conversion pending, got word %h chars %h valid %b ovf %b",
                 results_seen, got.word, got.chars, got.valid_res, got.overflow);
      mismatches++;
      return;
    end
    exp = pending.pop_front();
    if (got.word !== exp.word || got.chars !== exp.chars ||
        got.valid_res !== exp.valid_res || got.overflow !== exp.overflow) begin
      if (mismatches < 10)
        $display("result %0d: exp %h %h valid %b ovf %b, got %h %h valid %b ovf %b",
                 results_seen, exp.word, exp.chars, exp.valid_res, exp.overflow,
                 got.word, got.chars, got.valid_res, got.overflow);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return pending.size();
  endfunction
endclass

module tb_top;
  import b85_pkg::*;

  localparam int RANDOM_BEATS = 1950;
  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst_n;
  bit   hold_req;
  int   idle_mode;
  int   cycle_count;

  b85_in_if  in_bus ();
  b85_out_if out_bus ();

  b85_scoreboard sb = new();

  base85_word_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_input(op_t'(in_bus.operation), in_bus.word_in,
                    {in_bus.char_in_4, in_bus.char_in_3, in_bus.char_in_2,
                     in_bus.char_in_1, in_bus.char_in_0});
  end

  // accepted result beats are checked in order
  always @(posedge clk) begin
    b85_result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.word      = out_bus.word_out;
      got.chars     = {out_bus.char_out_4, out_bus.char_out_3, out_bus.char_out_2,
                       out_bus.char_out_1, out_bus.char_out_0};
      got.valid_res = out_bus.valid_res;
      got.overflow  = out_bus.overflow;
      sb.check_result(got);
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    int r;
    out_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        r = $urandom_range(0, 99);
        if (idle_mode == 1) begin
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 17) stall_left = $urandom_range(8, 30);
        end else if (idle_mode == 2) begin
          if (r < 35) stall_left = $urandom_range(1, 4);
          else if (r < 40) stall_left = $urandom_range(8, 30);
        end
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // offer one beat until it is taken, then maybe leave a gap
  task automatic send_beat(input op_t op, input logic [31:0] w, input logic [4:0][7:0] cs);
    int gap;
    int r;
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.word_in   <= w;
    in_bus.char_in_0 <= cs[0];
    in_bus.char_in_1 <= cs[1];
    in_bus.char_in_2 <= cs[2];
    in_bus.char_in_3 <= cs[3];
    in_bus.char_in_4 <= cs[4];
    do @(posedge clk); while (!in_bus.ready);
    gap = 0;
    r   = $urandom_range(0, 99);
    if (idle_mode == 1) begin
      if (r < 15) gap = $urandom_range(1, 3);
      else if (r < 17) gap = $urandom_range(10, 40);
    end else if (idle_mode == 2) begin
      if (r < 40) gap = $urandom_range(1, 4);
      else if (r < 45) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // encode beat; the unused characters still toggle
  task automatic send_encode(input logic [31:0] w);
    logic [4:0][7:0] cs;
    for (int k = 0; k < 5; k++) cs[k] = 8'($urandom_range(0, 255));
    send_beat(OP_ENCODE, w, cs);
  endtask

  // decode beat, c0 most significant; the unused word still toggles
  task automatic send_decode(input logic [7:0] c0, c1, c2, c3, c4);
    send_beat(OP_DECODE, $urandom, {c4, c3, c2, c1, c0});
  endtask

  function automatic logic [7:0] any_glyph();
    return sb.glyph[$urandom_range(0, 84)];
  endfunction

  initial begin
    logic [4:0][7:0] cs;
    logic [31:0]     w;
    int              sel;
    in_bus.valid     = 1'b0;
    in_bus.operation = 1'b0;
    in_bus.word_in   = '0;
    in_bus.char_in_0 = '0;
    in_bus.char_in_1 = '0;
    in_bus.char_in_2 = '0;
    in_bus.char_in_3 = '0;
    in_bus.char_in_4 = '0;
    hold_req         = 1'b0;
    idle_mode        = 0;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: word extremes and digit boundaries
    send_encode(32'h0000_0000);
    send_encode(32'hFFFF_FFFF);
    send_encode(32'd84);
    send_encode(32'd85);
    send_encode(32'd52200624);
    send_encode(32'd52200625);
    send_encode(32'hAAAA_AAAA);
    send_encode(32'h5555_5555);
    // directed: decode extremes, largest word, first wrapping value, largest value
    send_decode("0", "0", "0", "0", "0");
    send_decode("|", "N", "s", "C", "0");
    send_decode("|", "N", "s", "C", "1");
    send_decode("~", "~", "~", "~", "~");
    // punctuation part of the alphabet
    send_decode("!", "#", "$", "%", "&");
    send_decode("(", ")", "*", "+", "-");
    send_decode(";", "<", "=", ">", "?");
    send_decode("@", "^", "_", 8'h60, "{");
    send_decode("|", "}", "~", "9", "z");
    // bad characters: zero code, high codes, gaps in the alphabet
    send_decode(8'h00, "1", "2", "3", "4");
    send_decode("A", " ", "B", "C", "D");
    send_decode("a", "b", 8'h80, "c", "d");
    send_decode("0", "0", "0", 8'h22, "0");
    send_decode("Z", "Z", "Z", "Z", 8'hFF);
    send_decode(8'h7F, "0", "0", "0", "0");
    send_decode("0", ",", ".", "/", 8'h27);

    // random part
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      idle_mode = (i / 250) % 3;
      if (i == 520) hold_req = 1'b1;
      if (i == 1100) begin
        // let the pipe drain completely before going on
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 3))
          0: w = $urandom_range(0, 7225);
          1: w = 32'hFFFF_FFFF - $urandom_range(0, 1000);
          default: w = $urandom;
        endcase
        send_encode(w);
      end else begin
        for (int k = 0; k < 5; k++) cs[k] = any_glyph();
        // push toward the wrapping range now and then
        if ($urandom_range(0, 3) == 0) cs[0] = sb.glyph[$urandom_range(80, 84)];
        if (sel >= 85 && sel < 95) begin
          cs[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
        end else if (sel >= 95) begin
          for (int k = 0; k < 5; k++) cs[k] = 8'($urandom_range(0, 255));
        end
        send_decode(cs[0], cs[1], cs[2], cs[3], cs[4]);
      end
    end

    // wind down
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
